[hdl/fy_pkg.sv]
`timescale 1ns / 1ps

package fy_pkg;

	localparam int DATA_W = 32;
	localparam int RAND_W = 31;

	typedef struct packed {
		logic              start;
		logic [RAND_W-1:0] dividend;
		logic [RAND_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic              busy;
		logic              done;
		logic [RAND_W-1:0] quotient;
	} div_rsp_t;

endpackage

[hdl/fy_in_if.sv]
`timescale 1ns / 1ps

interface fy_in_if import fy_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [DATA_W-1:0] element_value;
	logic [RAND_W-1:0] random_word;
	logic              is_last;

	modport source (output valid, element_value, random_word, is_last, input ready);
	modport sink (input valid, element_value, random_word, is_last, output ready);
endinterface

[hdl/fy_out_if.sv]
`timescale 1ns / 1ps

interface fy_out_if import fy_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [DATA_W-1:0] element_value_out;
	logic              is_last_out;

	modport source (output valid, element_value_out, is_last_out, input ready);
	modport sink (input valid, element_value_out, is_last_out, output ready);
endinterface

[hdl/fy_ram.sv]
`timescale 1ns / 1ps

module fy_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[hdl/fy_div.sv]
`timescale 1ns / 1ps

module fy_div import fy_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	localparam int CNT_W = $clog2(RAND_W + 1);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [RAND_W-1:0] acc_q;
	logic [RAND_W-1:0] quo_q;
	logic [RAND_W-1:0] dsr_q;
	logic [RAND_W:0]   shifted;
	logic [RAND_W:0]   diff;
	logic              ge;
	logic              launch;

	assign launch  = req.start && !busy_q;
	assign shifted = {acc_q, quo_q[RAND_W-1]};
	assign diff    = shifted - {1'b0, dsr_q};
	assign ge      = shifted >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (launch) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(RAND_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (launch) begin
			acc_q <= '0;
			quo_q <= req.dividend;
			dsr_q <= req.divisor;
		end else if (busy_q) begin
			acc_q <= ge ? diff[RAND_W-1:0] : shifted[RAND_W-1:0];
			quo_q <= {quo_q[RAND_W-2:0], ge};
		end
	end

	assign rsp.busy     = busy_q;
	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

[hdl/fisher_yates_shuffler.sv]
`timescale 1ns / 1ps

// Fisher-Yates shuffler. Items are loaded one a cycle into an element memory and a random-word
// memory until an item marked last arrives (items beyond MAX_ELEMENTS are taken and dropped,
// though a last mark still ends the list). The pass then visits each position i of a list of
// n elements from 0 to n-2: a read of entry i and its random word, two divisions on a shared
// restoring divider that yields one quotient bit a cycle, then a read of entry j and two
// write-backs. The list is then delivered item by item, each one read from the memory and then
// presented until it is taken; the next list is taken only once the final item of the last one
// has left. No clearing pass is needed after reset.
module fisher_yates_shuffler import fy_pkg::*; #(
	parameter int          MAX_ELEMENTS  = 32,
	parameter int          ELEMENT_WIDTH = 32,
	parameter int unsigned RAND_LIMIT    = 2147483647
) (
	input logic      clk,
	input logic      arst_n,
	fy_in_if.sink    in_ch,
	fy_out_if.source out_ch
);

	localparam int SW    = (ELEMENT_WIDTH < DATA_W) ? ELEMENT_WIDTH : DATA_W;
	localparam int IW    = $clog2(MAX_ELEMENTS);
	localparam int CW    = $clog2(MAX_ELEMENTS + 1);
	localparam int SUM_W = RAND_W + 1;

	typedef enum logic [8:0] {
		S_LOAD      = 9'b000000001,
		S_RD_I      = 9'b000000010,
		S_DIV1      = 9'b000000100,
		S_DIV2      = 9'b000001000,
		S_RD_J      = 9'b000010000,
		S_WR_I      = 9'b000100000,
		S_WR_J      = 9'b001000000,
		S_EMIT_RD   = 9'b010000000,
		S_EMIT_SHOW = 9'b100000000
	} state_t;

	state_t        state_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] n_q;
	logic [IW-1:0] i_q;
	logic [IW-1:0] j_q;
	logic [IW-1:0] k_q;
	logic [SW-1:0] ei_q;

	logic              in_acc;
	logic              room;
	logic [CW-1:0]     n_next;
	logic [CW-1:0]     n_lim;
	logic [SUM_W-1:0]  j_sum;
	logic [IW-1:0]     j_next;
	logic              last_pos;

	logic          e_we;
	logic [IW-1:0] e_waddr;
	logic [SW-1:0] e_wdata;
	logic          e_re;
	logic [IW-1:0] e_raddr;
	logic [SW-1:0] e_rdata;
	logic          r_we;
	logic          r_re;
	logic [RAND_W-1:0] r_rdata;

	div_req_t div_req;
	div_rsp_t div_rsp;

	assign in_ch.ready = (state_q == S_LOAD);
	assign in_acc      = in_ch.valid && in_ch.ready;
	assign room        = count_q < CW'(MAX_ELEMENTS);
	assign n_next      = room ? count_q + CW'(1) : count_q;
	assign n_lim       = n_q - CW'(1);
	assign j_sum       = {1'b0, div_rsp.quotient} + SUM_W'(i_q);
	assign j_next      = (j_sum > SUM_W'(n_lim)) ? n_lim[IW-1:0] : j_sum[IW-1:0];
	assign last_pos    = CW'(k_q) == n_lim;

	// memory access per state
	always_comb begin
		e_we    = 1'b0;
		e_waddr = count_q[IW-1:0];
		e_wdata = in_ch.element_value[SW-1:0];
		e_re    = 1'b0;
		e_raddr = i_q;
		r_we    = 1'b0;
		r_re    = 1'b0;
		case (state_q)
			S_LOAD: begin
				e_we = in_acc && room;
				r_we = in_acc && room;
			end
			S_RD_I: begin
				e_re = 1'b1;
				r_re = 1'b1;
			end
			S_RD_J: begin
				e_re    = 1'b1;
				e_raddr = j_q;
			end
			S_WR_I: begin
				e_we    = 1'b1;
				e_waddr = i_q;
				e_wdata = e_rdata;
			end
			S_WR_J: begin
				e_we    = 1'b1;
				e_waddr = j_q;
				e_wdata = ei_q;
			end
			S_EMIT_RD: begin
				e_re    = 1'b1;
				e_raddr = k_q;
			end
			default: begin
			end
		endcase
	end

	// divider requests: range size first, then the scaled random word
	always_comb begin
		div_req.start    = 1'b0;
		div_req.dividend = RAND_W'(RAND_LIMIT);
		div_req.divisor  = RAND_W'(n_q - CW'(i_q));
		case (state_q)
			S_RD_I: begin
				div_req.start = 1'b1;
			end
			S_DIV1: begin
				div_req.start    = div_rsp.done;
				div_req.dividend = r_rdata;
				div_req.divisor  = div_rsp.quotient + RAND_W'(1);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
			count_q <= '0;
			n_q     <= '0;
			i_q     <= '0;
			k_q     <= '0;
		end else begin
			case (state_q)
				S_LOAD: begin
					if (in_acc) begin
						if (in_ch.is_last) begin
							n_q     <= n_next;
							count_q <= '0;
							i_q     <= '0;
							k_q     <= '0;
							state_q <= (n_next >= CW'(2)) ? S_RD_I : S_EMIT_RD;
						end else begin
							count_q <= n_next;
						end
					end
				end
				S_RD_I: begin
					state_q <= S_DIV1;
				end
				S_DIV1: begin
					if (div_rsp.done) begin
						state_q <= S_DIV2;
					end
				end
				S_DIV2: begin
					if (div_rsp.done) begin
						state_q <= S_RD_J;
					end
				end
				S_RD_J: begin
					state_q <= S_WR_I;
				end
				S_WR_I: begin
					state_q <= S_WR_J;
				end
				S_WR_J: begin
					if (CW'(i_q) + CW'(2) < n_q) begin
						i_q     <= i_q + IW'(1);
						state_q <= S_RD_I;
					end else begin
						state_q <= S_EMIT_RD;
					end
				end
				S_EMIT_RD: begin
					state_q <= S_EMIT_SHOW;
				end
				S_EMIT_SHOW: begin
					if (out_ch.ready) begin
						if (last_pos) begin
							state_q <= S_LOAD;
						end else begin
							k_q     <= k_q + IW'(1);
							state_q <= S_EMIT_RD;
						end
					end
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DIV1) begin
			ei_q <= e_rdata;
		end
		if (state_q == S_DIV2 && div_rsp.done) begin
			j_q <= j_next;
		end
	end

	fy_ram #(
		.WIDTH(SW),
		.DEPTH(MAX_ELEMENTS)
	) u_elem_ram (
		.clk  (clk),
		.we   (e_we),
		.waddr(e_waddr),
		.wdata(e_wdata),
		.re   (e_re),
		.raddr(e_raddr),
		.rdata(e_rdata)
	);

	fy_ram #(
		.WIDTH(RAND_W),
		.DEPTH(MAX_ELEMENTS)
	) u_rand_ram (
		.clk  (clk),
		.we   (r_we),
		.waddr(count_q[IW-1:0]),
		.wdata(in_ch.random_word),
		.re   (r_re),
		.raddr(i_q),
		.rdata(r_rdata)
	);

	fy_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (div_req),
		.rsp   (div_rsp)
	);

	assign out_ch.valid             = (state_q == S_EMIT_SHOW);
	assign out_ch.element_value_out = DATA_W'(e_rdata);
	assign out_ch.is_last_out       = last_pos;

	// loading and delivery never overlap
	assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ch.ready && out_ch.valid))
		else $error("input taken while an item is on offer");

	// swap partner stays inside the list and never behind the current position
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_RD_J |-> (CW'(j_q) < n_q) && (j_q >= i_q))
		else $error("swap index out of range");

	// divider is only started when free
	assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> !div_rsp.busy)
		else $error("divider started while busy");

	// element memory is written only while loading or swapping
	assert property (@(posedge clk) disable iff (!arst_n)
		e_we |-> (state_q == S_LOAD || state_q == S_WR_I || state_q == S_WR_J))
		else $error("stray element write");

	// after the final item leaves the block is ready for a new list
	assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.ready && out_ch.is_last_out |=> in_ch.ready && count_q == '0)
		else $error("not back to loading after the final item");

endmodule
